// ===== rtl/predictive_pi_heater_control_unit_assert.svh =====
// Assertion macros for the predictive PI heater controller.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PREDICTIVE_PI_HEATER_CONTROL_UNIT_ASSERT_SVH
`define PREDICTIVE_PI_HEATER_CONTROL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PPHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/pphc_pkg.sv =====
// Shared widths, register indexes, reset values and arithmetic constants
// for the predictive PI heater controller. No dependencies.
package pphc_pkg;

	localparam int TEMP_W     = 15;
	localparam int SETPT_W    = 13;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int MINPWM_W   = 7;
	localparam int DUTY_W     = 7;
	localparam int INTEG_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETPOINT,
		CFG_ZONE_ENTER,
		CFG_ZONE_EXIT,
		CFG_KP_GAIN,
		CFG_KI_PER_SAMPLE,
		CFG_INTEGRAL_LIMIT,
		CFG_FALLBACK_GAIN,
		CFG_FALLBACK_MIN_PWM
	} cfg_index_t;

	localparam logic [SETPT_W-1:0]  SETPOINT_RST   = 13'd3750;
	localparam logic [SETPT_W-1:0]  ZONE_ENTER_RST = 13'd3700;
	localparam logic [SETPT_W-1:0]  ZONE_EXIT_RST  = 13'd3650;
	localparam logic [GAIN_W-1:0]   KP_GAIN_RST    = 16'd4608;
	localparam logic [GAIN_W-1:0]   KI_RST         = 16'd256;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST      = 15'd12800;
	localparam logic [GAIN_W-1:0]   FB_GAIN_RST    = 16'd7680;
	localparam logic [MINPWM_W-1:0] FB_MIN_RST     = 7'd40;

	// Plausibility band of the prediction, in 1/100 degree.
	localparam logic signed [16:0] PRED_BELOW = 17'sd200;
	localparam logic signed [16:0] PRED_ABOVE = 17'sd150;
	localparam logic signed [16:0] PRED_MAX   = 17'sd16383;

	// Duty sums are in 1/25600 percent.
	localparam logic [21:0] DUTY_UNIT        = 22'd25600;
	localparam logic [21:0] FALLBACK_CAP_SUM = 22'd1536000;
	localparam logic [21:0] DUTY_FULL_SUM    = 22'd2560000;

	// Floor division by 100 of a signed 32-bit product: bias it positive by
	// 100 * 2^24, divide by reciprocal multiplication, then remove 2^24.
	localparam logic [31:0] DIV100_OFFSET = 32'd1677721600;
	localparam logic [31:0] DIV100_MAGIC  = 32'd2748779070;
	localparam int          DIV100_SHIFT  = 38;
	localparam logic signed [25:0] STEP_BIAS = 26'sd16777216;

	// Division by 100 of a 14-bit value (the sum already shifted down by 256).
	localparam logic [13:0] DUTY_MAGIC = 14'd10486;
	localparam int          DUTY_SHIFT = 20;

endpackage

// ===== rtl/pphc_in_if.sv =====
// Sample channel of the predictive PI heater controller: valid/ready plus
// the measured and predicted temperatures. Depends on pphc_pkg.
interface pphc_in_if;
	import pphc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [TEMP_W-1:0]  temp_measured;
	logic signed [TEMP_W-1:0]  temp_predicted;
	logic                      prediction_valid;

	modport source (output valid, output temp_measured, output temp_predicted,
		output prediction_valid, input ready);
	modport sink (input valid, input temp_measured, input temp_predicted,
		input prediction_valid, output ready);
endinterface

// ===== rtl/pphc_out_if.sv =====
// Result channel of the predictive PI heater controller: valid/ready plus
// drive duty, zone flag, used prediction and integral. Depends on pphc_pkg.
interface pphc_out_if;
	import pphc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [DUTY_W-1:0]         drive_percent;
	logic                      in_predictive_zone;
	logic signed [TEMP_W-1:0]  prediction_used;
	logic signed [INTEG_W-1:0] integral_value;

	modport source (output valid, output drive_percent, output in_predictive_zone,
		output prediction_used, output integral_value, input ready);
	modport sink (input valid, input drive_percent, input in_predictive_zone,
		input prediction_used, input integral_value, output ready);
endinterface

// ===== rtl/predictive_pi_heater_control_unit.sv =====
// Predictive PI heater controller, top level and datapath.
// Depends on pphc_pkg, pphc_in_if, pphc_out_if and the assertion macro header.
//
// Usage: each transfer on in_ch carries one sample (measured temperature,
// predicted temperature, prediction valid flag); each sample yields exactly one
// transfer on out_ch with the heater duty, the zone flag after the update, the
// prediction actually used and the integral after the update.
// The datapath is a five-register pipeline behind an input register: the
// gain multiplies, the reciprocal multiply for the integral step, the integral
// update, the clamped duty sums and the final divide each own one stage.
// The result is presented on out_ch from the output register, and
// one sample is taken every cycle while out_ch keeps up. The zone flag and
// the integral are updated in their stage as each sample passes, so samples
// in flight see them in order.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling; in_ch.ready drops only once every stage is
// occupied. Reset clears all stage valid bits, the zone flag (fallback law),
// the integral and loads the default register values.
// The user writes registers through cfg_we/cfg_index/cfg_wdata only while no
// sample is in flight (not enforced by the block); writes take effect at the next clock edge.
`include "predictive_pi_heater_control_unit_assert.svh"

module predictive_pi_heater_control_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	pphc_in_if.sink                            in_ch,
	pphc_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [pphc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pphc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import pphc_pkg::*;

	// Configuration registers.
	logic [SETPT_W-1:0]  setpoint_q;
	logic [SETPT_W-1:0]  zone_enter_q;
	logic [SETPT_W-1:0]  zone_exit_q;
	logic [GAIN_W-1:0]   kp_gain_q;
	logic [GAIN_W-1:0]   ki_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [GAIN_W-1:0]   fb_gain_q;
	logic [MINPWM_W-1:0] fb_min_q;

	// Controller state.
	logic                      zone_q;
	logic signed [INTEG_W-1:0] integ_q;

	// Stage valid bits and load enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;

	// Stage 1: input register.
	logic signed [TEMP_W-1:0] meas_s1, pred_in_s1;
	logic                     pvalid_s1;

	// Stage 2: gain products.
	logic signed [31:0]       prod_ki_s2, prod_kp_s2, prod_fb_s2;
	logic                     zone_s2;
	logic signed [TEMP_W-1:0] pred_s2;

	// Stage 3: integral step.
	logic signed [24:0]       step_s3;
	logic signed [31:0]       prod_kp_s3, prod_fb_s3;
	logic                     zone_s3;
	logic signed [TEMP_W-1:0] pred_s3;

	// Stage 4: updated integral.
	logic signed [INTEG_W-1:0] acc_s4;
	logic signed [31:0]        prod_kp_s4, prod_fb_s4;
	logic                      zone_s4;
	logic signed [TEMP_W-1:0]  pred_s4;

	// Stage 5: clamped duty sum divided by 256.
	logic [13:0]               scaled_s5;
	logic                      zone_s5;
	logic signed [TEMP_W-1:0]  pred_s5;
	logic signed [INTEG_W-1:0] acc_s5;

	// Output register.
	logic [DUTY_W-1:0]         drive_q;
	logic                      zone_o_q;
	logic signed [TEMP_W-1:0]  pred_o_q;
	logic signed [INTEG_W-1:0] integ_o_q;

	// Stage A combinational signals.
	logic signed [16:0] meas_x, pred_x, pred_a, pred_b, pred_c;
	logic signed [15:0] meas16, pred16, enter16, exit16, sp16;
	logic signed [15:0] err_real, err_pred;
	logic               zone_nxt;
	logic signed [32:0] prod_ki_full, prod_kp_full, prod_fb_full;

	// Stage B combinational signals.
	logic [31:0]        biased_b;
	logic [63:0]        quo_full;
	logic [24:0]        quo_b;
	logic signed [25:0] step_b;

	// Stage C combinational signals.
	logic signed [25:0]        acc_sum, lim26;
	logic signed [INTEG_W-1:0] acc_cl, acc_nxt, lim16;

	// Stage D combinational signals.
	logic signed [22:0] acc100;
	logic signed [33:0] sum_pi;
	logic [21:0]        sum_pi_cl;
	logic signed [32:0] sum_fb, fb_lo33, fb_cap33;
	logic [21:0]        fb_lo, sum_fb_cl, sum_sel;

	// Stage E combinational signals.
	logic [27:0] duty_full;

	// Handshake: each stage loads when it is empty or its content moves on.
	assign en_out = !out_v_q || out_ch.ready;
	assign en_s5  = !v_s5 || en_out;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;

	assign out_ch.valid              = out_v_q;
	assign out_ch.drive_percent      = drive_q;
	assign out_ch.in_predictive_zone = zone_o_q;
	assign out_ch.prediction_used    = pred_o_q;
	assign out_ch.integral_value     = integ_o_q;

	// Stage A: prediction limits, zone hysteresis, errors and gain products.
	always_comb begin
		meas_x = {{2{meas_s1[TEMP_W-1]}}, meas_s1};
		pred_x = pvalid_s1 ? {{2{pred_in_s1[TEMP_W-1]}}, pred_in_s1} : meas_x;
		// A prediction far below the measurement is discarded altogether.
		pred_a = (pred_x < meas_x - PRED_BELOW) ? meas_x : pred_x;
		pred_b = (pred_a > meas_x + PRED_ABOVE) ? meas_x + PRED_ABOVE : pred_a;
		pred_c = (pred_b > PRED_MAX) ? PRED_MAX : pred_b;

		meas16  = {meas_s1[TEMP_W-1], meas_s1};
		pred16  = pred_c[15:0];
		enter16 = {3'b000, zone_enter_q};
		exit16  = {3'b000, zone_exit_q};
		sp16    = {3'b000, setpoint_q};

		// Enter test first, exit test second on the same sample.
		zone_nxt = (zone_q || (meas16 >= enter16)) && !(meas16 < exit16);

		err_real = sp16 - meas16;
		err_pred = sp16 - pred16;

		prod_ki_full = err_real * $signed({1'b0, ki_q});
		prod_kp_full = err_pred * $signed({1'b0, kp_gain_q});
		prod_fb_full = err_real * $signed({1'b0, fb_gain_q});
	end

	// Stage B: integral step, floor of the product divided by 100.
	always_comb begin
		biased_b = $unsigned(prod_ki_s2) + DIV100_OFFSET;
		quo_full = 64'(biased_b) * 64'(DIV100_MAGIC);
		quo_b    = quo_full[DIV100_SHIFT+24:DIV100_SHIFT];
		step_b   = $signed({1'b0, quo_b}) - STEP_BIAS;
	end

	// Stage C: saturating integral update, held outside the zone.
	always_comb begin
		acc_sum = {{10{integ_q[INTEG_W-1]}}, integ_q} + {step_s3[24], step_s3};
		lim26   = {11'b0, limit_q};
		lim16   = {1'b0, limit_q};
		if (acc_sum > lim26) begin
			acc_cl = lim16;
		end else if (acc_sum < -lim26) begin
			acc_cl = -lim16;
		end else begin
			acc_cl = acc_sum[INTEG_W-1:0];
		end
		acc_nxt = zone_s3 ? acc_cl : integ_q;
	end

	// Stage D: duty sums of both laws with their clamps.
	always_comb begin
		acc100 = {{7{acc_s4[INTEG_W-1]}}, acc_s4} * 23'sd100;
		sum_pi = {{2{prod_kp_s4[31]}}, prod_kp_s4} + {{11{acc100[22]}}, acc100};
		if (sum_pi < 34'sd0) begin
			sum_pi_cl = '0;
		end else if (sum_pi > $signed({12'b0, DUTY_FULL_SUM})) begin
			sum_pi_cl = DUTY_FULL_SUM;
		end else begin
			sum_pi_cl = sum_pi[21:0];
		end

		fb_lo    = 22'(fb_min_q) * DUTY_UNIT;
		fb_lo33  = {11'b0, fb_lo};
		fb_cap33 = {11'b0, FALLBACK_CAP_SUM};
		sum_fb   = {prod_fb_s4[31], prod_fb_s4};
		// A minimum above the cap wins only for sums below the minimum.
		if (sum_fb < fb_lo33) begin
			sum_fb_cl = fb_lo;
		end else if (sum_fb > fb_cap33) begin
			sum_fb_cl = FALLBACK_CAP_SUM;
		end else begin
			sum_fb_cl = sum_fb[21:0];
		end

		sum_sel = zone_s4 ? sum_pi_cl : sum_fb_cl;
	end

	// Stage E: the remaining division by 100.
	assign duty_full = 28'(scaled_s5) * 28'(DUTY_MAGIC);

	// Control state, configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			out_v_q      <= 1'b0;
			zone_q       <= 1'b0;
			integ_q      <= '0;
			setpoint_q   <= SETPOINT_RST;
			zone_enter_q <= ZONE_ENTER_RST;
			zone_exit_q  <= ZONE_EXIT_RST;
			kp_gain_q    <= KP_GAIN_RST;
			ki_q         <= KI_RST;
			limit_q      <= LIMIT_RST;
			fb_gain_q    <= FB_GAIN_RST;
			fb_min_q     <= FB_MIN_RST;
		end else begin
			if (en_s1) v_s1 <= in_ch.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_out) out_v_q <= v_s5;

			if (v_s1 && en_s2) begin
				zone_q <= zone_nxt;
			end
			if (v_s3 && en_s4) begin
				integ_q <= acc_nxt;
			end

			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_SETPOINT:         setpoint_q   <= cfg_wdata[SETPT_W-1:0];
					CFG_ZONE_ENTER:       zone_enter_q <= cfg_wdata[SETPT_W-1:0];
					CFG_ZONE_EXIT:        zone_exit_q  <= cfg_wdata[SETPT_W-1:0];
					CFG_KP_GAIN:          kp_gain_q    <= cfg_wdata[GAIN_W-1:0];
					CFG_KI_PER_SAMPLE:    ki_q         <= cfg_wdata[GAIN_W-1:0];
					CFG_INTEGRAL_LIMIT:   limit_q      <= cfg_wdata[LIMIT_W-1:0];
					CFG_FALLBACK_GAIN:    fb_gain_q    <= cfg_wdata[GAIN_W-1:0];
					CFG_FALLBACK_MIN_PWM: fb_min_q     <= cfg_wdata[MINPWM_W-1:0];
				endcase
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			meas_s1    <= in_ch.temp_measured;
			pred_in_s1 <= in_ch.temp_predicted;
			pvalid_s1  <= in_ch.prediction_valid;
		end
		if (en_s2) begin
			prod_ki_s2 <= prod_ki_full[31:0];
			prod_kp_s2 <= prod_kp_full[31:0];
			prod_fb_s2 <= prod_fb_full[31:0];
			zone_s2    <= zone_nxt;
			pred_s2    <= pred_c[TEMP_W-1:0];
		end
		if (en_s3) begin
			step_s3    <= step_b[24:0];
			prod_kp_s3 <= prod_kp_s2;
			prod_fb_s3 <= prod_fb_s2;
			zone_s3    <= zone_s2;
			pred_s3    <= pred_s2;
		end
		if (en_s4) begin
			acc_s4     <= acc_nxt;
			prod_kp_s4 <= prod_kp_s3;
			prod_fb_s4 <= prod_fb_s3;
			zone_s4    <= zone_s3;
			pred_s4    <= pred_s3;
		end
		if (en_s5) begin
			scaled_s5 <= sum_sel[21:8];
			zone_s5   <= zone_s4;
			pred_s5   <= pred_s4;
			acc_s5    <= acc_s4;
		end
		if (en_out) begin
			drive_q   <= duty_full[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
			zone_o_q  <= zone_s5;
			pred_o_q  <= pred_s5;
			integ_o_q <= acc_s5;
		end
	end

	`PPHC_ASSERT_IMPL(a_fb_duty, clk, arst_n, out_v_q && !zone_o_q,
		drive_q <= 7'd60 || drive_q == fb_min_q, "fallback duty outside its band")
	`PPHC_ASSERT_IMPL(a_pi_duty, clk, arst_n, out_v_q && zone_o_q,
		drive_q <= 7'd100, "predictive duty above full scale")
	`PPHC_ASSERT_IMPL(a_integ_bound, clk, arst_n, out_v_q && zone_o_q,
		integ_o_q <= lim16 && integ_o_q >= -lim16, "integral outside its limit")
	`PPHC_ASSERT_NEXT(a_zone_hold, clk, arst_n, !(v_s1 && en_s2),
		$stable(zone_q), "zone flag changed with no sample passing")
	`PPHC_ASSERT_IMPL(a_stall_only_full, clk, arst_n, !in_ch.ready,
		out_v_q && !out_ch.ready, "input stalled while output not blocked")

endmodule
